// ----- rtl/core/npi_pkg.sv -----
package npi_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int Q_W            = 32;
  localparam int IDX_IN_W       = 4;
  localparam int CNT_IN_W       = 5;
  // two quotient bits per cycle over a 64-bit numerator
  localparam int DIV_CYCLES     = 32;
  localparam int DIV_CW         = $clog2(DIV_CYCLES);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_DUP = 2'd1,
    STAT_SAT = 2'd2,
    STAT_BAD = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR,
    S_RD_A,
    S_RD_B,
    S_CAP,
    S_CHK,
    S_MUL1,
    S_MUL2,
    S_DIFF,
    S_DIVLD,
    S_DIV,
    S_SAT,
    S_FIN_RD,
    S_FIN_WAIT,
    S_DONE
  } npi_state_t;

  typedef struct packed {
    npi_state_t state;
    logic       accept;
    logic       bad_idx;
    logic       out_load;
  } npi_cmd_t;

  typedef struct packed {
    logic den_zero;
  } npi_sts_t;

endpackage

// ----- rtl/core/npi_ifs.sv -----
interface npi_item_if import npi_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [IDX_IN_W-1:0]        point_index;
  logic signed [Q_W-1:0]      x_value;
  logic signed [Q_W-1:0]      y_value;

  modport source (output valid, req_type, point_index, x_value, y_value, input ready);
  modport sink   (input valid, req_type, point_index, x_value, y_value, output ready);
endinterface

interface npi_result_if import npi_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] result_value;
  logic [1:0]            status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ----- rtl/core/npi_ram.sv -----
module npi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/npi_ctrl.sv -----
module npi_ctrl import npi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int IDX_W      = $clog2(MAX_POINTS),
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_IN_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [IDX_IN_W-1:0] point_index,
  output logic                out_valid,
  input  logic                out_ready,
  output npi_cmd_t            cmd,
  input  npi_sts_t            sts,
  output logic [IDX_W-1:0]    addr_n,
  output logic [IDX_W-1:0]    addr_nk,
  output logic [IDX_W-1:0]    addr_n1
);

  npi_state_t          state, state_next;
  logic [CNT_IN_W-1:0] point_count;
  logic [CNT_W-1:0]    eff_cnt;
  logic [CNT_W-1:0]    n, n_next;
  logic [CNT_W-1:0]    k, k_next;
  logic [DIV_CW-1:0]   div_cnt, div_cnt_next;
  logic                out_load;
  logic                accept;

  // count of 0 behaves as 1, anything above capacity as capacity
  always_comb begin
    if (point_count == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      eff_cnt = CNT_W'(MAX_POINTS);
    end else begin
      eff_cnt = CNT_W'(point_count);
    end
  end

  assign accept  = in_valid && in_ready;
  assign addr_n  = IDX_W'(n);
  assign addr_nk = IDX_W'(n + k);
  assign addr_n1 = IDX_W'(n + 1'b1);

  assign cmd.state    = state;
  assign cmd.accept   = accept;
  assign cmd.bad_idx  = 32'(point_index) >= 32'(eff_cnt);
  assign cmd.out_load = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= CNT_IN_W'(1);
      n           <= '0;
      k           <= '0;
      div_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state   <= state_next;
      n       <= n_next;
      k       <= k_next;
      div_cnt <= div_cnt_next;
      if (cfg_we) begin
        point_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    k_next       = k;
    div_cnt_next = div_cnt;
    in_ready     = (state == S_IDLE);
    out_load     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_QUERY) begin
            n_next     = '0;
            state_next = S_COPY_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: begin
        if (n + 1'b1 == eff_cnt) begin
          n_next     = '0;
          k_next     = CNT_W'(1);
          state_next = (eff_cnt == CNT_W'(1)) ? S_FIN_RD : S_RD_A;
        end else begin
          n_next     = n + 1'b1;
          state_next = S_COPY_RD;
        end
      end
      S_RD_A:  state_next = S_RD_B;
      S_RD_B:  state_next = S_CAP;
      S_CAP:   state_next = S_CHK;
      // duplicate abscissa ends the query at once
      S_CHK:   state_next = sts.den_zero ? S_FIN_RD : S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_DIFF;
      S_DIFF:  state_next = S_DIVLD;
      S_DIVLD: begin
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CW'(DIV_CYCLES - 1)) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        if (n + k + 1'b1 == eff_cnt) begin
          n_next     = '0;
          k_next     = k + 1'b1;
          state_next = (k + 1'b1 == eff_cnt) ? S_FIN_RD : S_RD_A;
        end else begin
          n_next     = n + 1'b1;
          state_next = S_RD_A;
        end
      end
      S_FIN_RD:   state_next = S_FIN_WAIT;
      S_FIN_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_QUERY) |=> (state == S_COPY_RD))
    else $error("query did not start the copy pass");

  a_load_finishes: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_LOAD) |=> (state == S_DONE))
    else $error("load did not go straight to result");

  a_tableau_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_A) |-> (k != '0 && 32'(n) + 32'(k) < 32'(eff_cnt)))
    else $error("tableau index out of range");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("finished word not presented");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVLD) |=> (state == S_DIV && div_cnt == '0))
    else $error("divider not restarted");

endmodule

// ----- rtl/core/npi_dp.sv -----
module npi_dp import npi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int IDX_W      = $clog2(MAX_POINTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  npi_cmd_t              cmd,
  output npi_sts_t              sts,
  input  logic [IDX_W-1:0]      addr_n,
  input  logic [IDX_W-1:0]      addr_nk,
  input  logic [IDX_W-1:0]      addr_n1,
  input  logic                  req_type,
  input  logic [IDX_IN_W-1:0]   point_index,
  input  logic signed [Q_W-1:0] x_value,
  input  logic signed [Q_W-1:0] y_value,
  output logic signed [Q_W-1:0] result_value,
  output logic [1:0]            status
);

  logic                  pt_we, tab_we;
  logic [IDX_W-1:0]      x_raddr, tab_raddr;
  logic [Q_W-1:0]        x_rd, y_rd, tab_rd, tab_wdata;
  logic signed [Q_W-1:0] t_r, xi_r, xj_r, pa_r, pb_r;
  logic signed [32:0]    den_r;
  logic signed [Q_W-1:0] mul_a;
  logic signed [32:0]    mul_b;
  logic signed [64:0]    prod_full;
  logic signed [63:0]    p1_r, p2_r;
  logic signed [64:0]    diff_r;
  logic                  nneg_r;
  logic [31:0]           dm_r;
  logic [31:0]           rem_r, rem_step;
  logic [63:0]           quo_r, quo_step;
  logic [32:0]           sh;
  logic                  qneg, sat_hit;
  logic [Q_W-1:0]        sat_val;
  logic                  sat_r, dup_r;
  logic [Q_W-1:0]        fin_val;
  status_t               fin_status;

  assign pt_we  = cmd.accept && req_type == REQ_LOAD && !cmd.bad_idx;
  assign tab_we = (cmd.state == S_COPY_WR) || (cmd.state == S_SAT);
  assign tab_wdata = (cmd.state == S_SAT) ? sat_val : y_rd;
  assign x_raddr = (cmd.state == S_RD_B) ? addr_nk : addr_n;

  always_comb begin
    case (cmd.state)
      S_RD_B:   tab_raddr = addr_n1;
      S_FIN_RD: tab_raddr = '0;
      default:  tab_raddr = addr_n;
    endcase
  end

  npi_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(pt_we), .waddr(IDX_W'(point_index)), .wdata(x_value),
    .raddr(x_raddr), .rdata(x_rd)
  );

  npi_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .we(pt_we), .waddr(IDX_W'(point_index)), .wdata(y_value),
    .raddr(addr_n), .rdata(y_rd)
  );

  npi_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_tab_ram (
    .clk(clk), .we(tab_we), .waddr(addr_n), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rd)
  );

  assign sts.den_zero = (xi_r == xj_r);

  // one shared multiplier, used for both products
  assign mul_a     = (cmd.state == S_MUL1) ? pa_r : pb_r;
  assign mul_b     = (cmd.state == S_MUL1) ? (33'(t_r) - 33'(xj_r)) : (33'(t_r) - 33'(xi_r));
  assign prod_full = mul_a * mul_b;

  // two restoring steps per cycle
  always_comb begin
    rem_step = rem_r;
    quo_step = quo_r;
    sh       = '0;
    for (int i = 0; i < 2; i++) begin
      sh       = {rem_step, quo_step[63]};
      quo_step = {quo_step[62:0], 1'b0};
      if (sh >= {1'b0, dm_r}) begin
        sh          = sh - {1'b0, dm_r};
        quo_step[0] = 1'b1;
      end
      rem_step = sh[31:0];
    end
  end

  // signed quotient clamped to q16.16 range
  always_comb begin
    qneg    = (nneg_r != den_r[32]) && (quo_r != '0);
    sat_hit = 1'b0;
    if (qneg) begin
      if (quo_r > 64'h0000_0000_8000_0000) begin
        sat_hit = 1'b1;
        sat_val = 32'h8000_0000;
      end else begin
        sat_val = 32'(-quo_r);
      end
    end else if (quo_r > 64'h0000_0000_7fff_ffff) begin
      sat_hit = 1'b1;
      sat_val = 32'h7fff_ffff;
    end else begin
      sat_val = quo_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_r <= 1'b0;
      dup_r <= 1'b0;
    end else begin
      if (cmd.accept && req_type == REQ_QUERY) begin
        sat_r <= 1'b0;
        dup_r <= 1'b0;
      end
      if (cmd.state == S_CHK && sts.den_zero) begin
        dup_r <= 1'b1;
      end
      if (cmd.state == S_SAT && sat_hit) begin
        sat_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r <= x_value;
      if (req_type == REQ_LOAD) begin
        fin_val    <= '0;
        fin_status <= cmd.bad_idx ? STAT_BAD : STAT_OK;
      end
    end
    case (cmd.state)
      S_RD_B: begin
        xi_r <= x_rd;
        pa_r <= tab_rd;
      end
      S_CAP: begin
        xj_r <= x_rd;
        pb_r <= tab_rd;
      end
      S_CHK:   den_r <= 33'(xi_r) - 33'(xj_r);
      S_MUL1:  p1_r  <= prod_full[63:0];
      S_MUL2:  p2_r  <= prod_full[63:0];
      S_DIFF:  diff_r <= 65'(p1_r) - 65'(p2_r);
      S_DIVLD: begin
        nneg_r <= diff_r[64];
        quo_r  <= diff_r[64] ? 64'(-diff_r) : diff_r[63:0];
        rem_r  <= '0;
        dm_r   <= den_r[32] ? 32'(-den_r) : den_r[31:0];
      end
      S_DIV: begin
        quo_r <= quo_step;
        rem_r <= rem_step;
      end
      S_FIN_WAIT: begin
        fin_val <= dup_r ? '0 : tab_rd;
        if (dup_r) begin
          fin_status <= STAT_DUP;
        end else begin
          fin_status <= sat_r ? STAT_SAT : STAT_OK;
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      result_value <= fin_val;
      status       <= fin_status;
    end
  end

endmodule

// ----- rtl/core/neville_polynomial_interpolator.sv -----
// neville polynomial interpolator, signed q16.16
// item channel (sink): req_type 0 loads point (x_value, y_value) into slot
// point_index; req_type 1 evaluates the polynomial through the first
// point_count stored points at x_value.
// result channel (source): one word per item, result_value and status
// (0 ok, 1 duplicate abscissa, 2 saturated, 3 bad index).
// cfg_we/cfg_data write point_count; write it only while the block is idle.
// a load goes from accept straight to the done state, then its result is registered.
// a query first copies the stored ordinates into the tableau; each tableau
// update then does the memory reads, two multiplies through one shared
// multiplier, a pass through the 2-bit-per-cycle divider and the write back.
// one item is worked on at a time; the next item is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// a stalled receiver holds that word; the following result waits for it.
// reset clears control state and sets point_count to 1; point memories are
// undefined until loaded.
module neville_polynomial_interpolator import npi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_IN_W-1:0] cfg_data,
  npi_item_if.sink            item,
  npi_result_if.source        result
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  npi_cmd_t         cmd;
  npi_sts_t         sts;
  logic [IDX_W-1:0] addr_n, addr_nk, addr_n1;

  npi_ctrl #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(item.valid), .in_ready(item.ready),
    .req_type(item.req_type), .point_index(item.point_index),
    .out_valid(result.valid), .out_ready(result.ready),
    .cmd(cmd), .sts(sts),
    .addr_n(addr_n), .addr_nk(addr_nk), .addr_n1(addr_n1)
  );

  npi_dp #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .sts(sts),
    .addr_n(addr_n), .addr_nk(addr_nk), .addr_n1(addr_n1),
    .req_type(item.req_type), .point_index(item.point_index),
    .x_value(item.x_value), .y_value(item.y_value),
    .result_value(result.result_value), .status(result.status)
  );

endmodule

// ----- tb/npi_tb_scoreboard.sv -----
package npi_tb_scoreboard_pkg;
  import npi_pkg::*;

  class interp_scoreboard;
    logic signed [31:0] pt_x [16];
    logic signed [31:0] pt_y [16];
    logic [4:0] npoints;
    logic signed [31:0] want_value [$];
    status_t want_status [$];
    int errors;

    function new();
      npoints = 5'd1;
      errors = 0;
      for (int i = 0; i < 16; i++) begin
        pt_x[i] = '0;
        pt_y[i] = '0;
      end
    endfunction

    function int eff_count();
      int c;
      c = npoints;
      if (c == 0) c = 1;
      if (c > 16) c = 16;
      return c;
    endfunction

    // one tableau step with truncating division and clamp
    function logic signed [31:0] tableau_step(logic signed [31:0] pa, logic signed [31:0] pb,
        logic signed [32:0] da, logic signed [32:0] db, logic signed [32:0] den, ref bit sat);
      logic signed [127:0] num, q;
      num = 128'(pa) * 128'(da) - 128'(pb) * 128'(db);
      q = num / 128'(den);
      if (q > 128'sh7fffffff) begin
        sat = 1;
        return 32'sh7fffffff;
      end
      if (q < -128'sh80000000) begin
        sat = 1;
        return 32'sh80000000;
      end
      return q[31:0];
    endfunction

    function void note_item(logic rtype, logic [3:0] idx, logic signed [31:0] xv,
        logic signed [31:0] yv);
      int cnt;
      logic signed [31:0] tab [16];
      logic signed [32:0] den;
      bit sat, dup;
      cnt = eff_count();
      sat = 0;
      dup = 0;
      if (rtype == REQ_LOAD) begin
        if (idx >= cnt) begin
          want_value.push_back('0);
          want_status.push_back(STAT_BAD);
        end else begin
          pt_x[idx] = xv;
          pt_y[idx] = yv;
          want_value.push_back('0);
          want_status.push_back(STAT_OK);
        end
        return;
      end
      for (int n = 0; n < cnt; n++) tab[n] = pt_y[n];
      for (int k = 1; k < cnt && !dup; k++) begin
        for (int n = 0; n + k < cnt; n++) begin
          den = 33'(pt_x[n]) - 33'(pt_x[n+k]);
          if (den == 0) begin
            dup = 1;
            break;
          end
          tab[n] = tableau_step(tab[n], tab[n+1], 33'(xv) - 33'(pt_x[n+k]),
                                33'(xv) - 33'(pt_x[n]), den, sat);
        end
      end
      if (dup) begin
        want_value.push_back('0);
        want_status.push_back(STAT_DUP);
      end else begin
        want_value.push_back(tab[0]);
        want_status.push_back(sat ? STAT_SAT : STAT_OK);
      end
    endfunction

    function void check_word(logic signed [31:0] rv, logic [1:0] st);
      if (want_value.size() == 0) begin
        $error("unexpected word: result_value %0d status %0d", rv, st);
        errors++;
        return;
      end
      if (rv !== want_value[0]) begin
        $error("result_value: expected %0d actual %0d", want_value[0], rv);
        errors++;
      end
      if (st !== want_status[0]) begin
        $error("status: expected %0d actual %0d", want_status[0], st);
        errors++;
      end
      void'(want_value.pop_front());
      void'(want_status.pop_front());
    endfunction
  endclass
endpackage

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npi_pkg::*;
  import npi_tb_scoreboard_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CNT_IN_W-1:0] cfg_data = '0;
  npi_item_if item ();
  npi_result_if result ();

  neville_polynomial_interpolator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .item(item.sink), .result(result.source)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  interp_scoreboard board = new();
  int sent = 0;
  int got = 0;

  initial begin
    item.valid = 0;
    item.req_type = REQ_LOAD;
    item.point_index = '0;
    item.x_value = '0;
    item.y_value = '0;
    result.ready = 0;
  end

  // valid is dropped only when a gap follows, so a back to back word never
  // sees two updates of valid at one falling edge
  task automatic send_word(logic rtype, logic [3:0] idx, logic signed [31:0] xv,
      logic signed [31:0] yv);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      item.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    item.valid <= 1;
    item.req_type <= rtype;
    item.point_index <= idx;
    item.x_value <= xv;
    item.y_value <= yv;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    board.note_item(rtype, idx, xv, yv);
    sent++;
    @(negedge clk);
  endtask

  // wait for all words, then the worst-case tail of a load
  task automatic drain_and_set(logic [4:0] n);
    item.valid <= 0;
    while (got < sent) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we <= 0;
    board.npoints = n;
  endtask

  // points on a small grid with distinct abscissas
  task automatic load_points(int cnt, int spread);
    for (int i = 0; i < cnt; i++)
      send_word(REQ_LOAD, i[3:0], 32'((i - cnt / 2) * spread + $urandom_range(0, 255)),
                32'($urandom_range(0, 32'h60000) - 32'h30000));
  endtask

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      board.check_word(result.result_value, result.status);
      got++;
    end
  end

  initial begin
    int r;
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 9);
      result.ready <= (r < 3) ? 1'b0 : 1'b1;
      if (r >= 7) repeat ($urandom_range(1, 4)) @(negedge clk);
      else @(negedge clk);
    end
  end

  initial begin
    int c;
    int sz [5] = '{1, 2, 3, 5, 16};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: single point, extremes, bad index, duplicate, saturation
    send_word(REQ_LOAD, 4'd0, 32'sh80000000, 32'sh7fffffff);
    send_word(REQ_QUERY, 4'd15, 32'sh7fffffff, 32'sh80000000);
    send_word(REQ_LOAD, 4'd1, 32'sh7fffffff, 32'sh80000000);
    send_word(REQ_LOAD, 4'd15, 32'hffffffff, 32'hffffffff);
    send_word(REQ_LOAD, 4'd0, 32'sh80000000, 32'sh80000000);
    drain_and_set(5'd2);
    send_word(REQ_LOAD, 4'd1, 32'sh7fffffff, 32'sh7fffffff);
    send_word(REQ_QUERY, 4'd0, 32'sh80000000, 32'sh0);
    send_word(REQ_QUERY, 4'd0, 32'sh7fffffff, 32'sh0);
    send_word(REQ_LOAD, 4'd1, 32'sh80000000, 32'sh10000);
    send_word(REQ_QUERY, 4'd0, 32'sh0, 32'sh0);
    send_word(REQ_LOAD, 4'd0, 32'sh0, 32'sh7fffffff);
    send_word(REQ_LOAD, 4'd1, 32'sh1, 32'sh80000000);
    send_word(REQ_QUERY, 4'd0, 32'sh7fff0000, 32'sh0);
    send_word(REQ_LOAD, 4'd2, 32'sh1, 32'sh1);
    drain_and_set(5'd0);
    send_word(REQ_LOAD, 4'd1, 32'sh1, 32'sh1);
    send_word(REQ_QUERY, 4'd0, 32'sh1234, 32'sh0);
    drain_and_set(5'd31);
    send_word(REQ_LOAD, 4'd15, 32'sh0, 32'sh0);
    drain_and_set(5'd16);
    load_points(16, 32'sh10000);
    send_word(REQ_QUERY, 4'd0, 32'sh8000, 32'sh0);
    send_word(REQ_QUERY, 4'd0, 32'sh7fffffff, 32'sh0);
    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      c = (ph == 6) ? 16 : sz[$urandom_range(0, 3)];
      drain_and_set(5'(c));
      load_points(c, $urandom_range(1, 4) * 32'h8000);
      for (int j = 0; j < 8; j++) begin
        case ($urandom_range(0, 5))
          0: send_word(REQ_LOAD, 4'($urandom), $urandom, $urandom);
          1: send_word(REQ_QUERY, 4'($urandom), $urandom, $urandom);
          2: send_word(REQ_LOAD, 4'($urandom_range(0, c - 1)),
                       32'($urandom_range(0, 32'h40000) - 32'h20000), $urandom);
          default: send_word(REQ_QUERY, 4'($urandom),
                             32'($urandom_range(0, 32'h80000) - 32'h40000), $urandom);
        endcase
      end
    end
    item.valid <= 0;
    while (got < sent) @(negedge clk);
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.want_value.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb: done, errors");
    $finish;
  end
endmodule
